/* rtl/core/icer_pkg.sv */
// Shared types, header offsets and helpers of the ICMP echo reply rewriter.
`timescale 1ns / 1ps

package icer_pkg;

	// header geometry (Ethernet + 20-byte IPv4 + ICMP up to the checksum)
	localparam int HEADER_BYTES = 38;
	localparam int POS_W        = 6;

	typedef logic [POS_W-1:0] pos_t;

	localparam pos_t POS_MAC_SRC   = 6'd6;
	localparam pos_t POS_ETH_TYPE  = 6'd12;
	localparam pos_t POS_IP_SRC    = 6'd26;
	localparam pos_t POS_IP_DST    = 6'd30;
	localparam pos_t POS_ICMP_TYPE = 6'd34;
	localparam pos_t POS_CSUM_HI   = 6'd36;
	localparam pos_t POS_CSUM_LO   = 6'd37;

	localparam logic [7:0]  TYPE_ECHO_REQUEST = 8'h08;
	localparam logic [7:0]  TYPE_ECHO_REPLY   = 8'h00;
	localparam logic [15:0] CSUM_ADJ          = 16'h0800;

	// register select, taken from paddr[3]
	localparam logic REG_OWN_MAC = 1'b0;
	localparam logic REG_OWN_IP  = 1'b1;

	// one queue entry: a header flush command or a forwarded byte
	typedef struct packed {
		logic        is_hdr;
		logic [7:0]  data;
		logic        last;
		logic [15:0] csum;
	} qent_t;

	// header store write port
	typedef struct packed {
		logic       en;
		pos_t       addr;
		logic [7:0] data;
	} wr_t;

	// store address read for reply byte k: the MACs and the IPs trade places
	function automatic pos_t hdr_rd_addr(pos_t k);
		pos_t a;
		a = k;
		if (k < POS_MAC_SRC)
			a = k + POS_MAC_SRC;
		else if (k >= POS_IP_DST && k < POS_ICMP_TYPE)
			a = k - 6'd4;
		return a;
	endfunction

endpackage

/* rtl/core/icer_if.sv */
// Byte stream channels of the rewriter: received frame and reply frame.
`timescale 1ns / 1ps

interface icer_rx_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;
	logic       rx_last;

	modport source (output valid, output rx_byte, output rx_last, input ready);
	modport sink (input valid, input rx_byte, input rx_last, output ready);
endinterface

interface icer_tx_if;
	logic       valid;
	logic       ready;
	logic [7:0] tx_byte;
	logic       tx_last;

	modport source (output valid, output tx_byte, output tx_last, input ready);
	modport sink (input valid, input tx_byte, input tx_last, output ready);
endinterface

/* rtl/core/icer_front.sv */
// Front end: takes received bytes, stores the header and classifies the frame.
`timescale 1ns / 1ps

module icer_front
	import icer_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	icer_rx_if.sink      rx,
	output logic         q_valid,
	input  logic         q_ready,
	output qent_t        q_data,
	input  logic         hdr_done,
	output wr_t          wr
);

	typedef enum logic [2:0] {
		MODE_COLLECT = 3'b001,
		MODE_FORWARD = 3'b010,
		MODE_DISCARD = 3'b100
	} mode_t;

	mode_t       mode_q;
	pos_t        pos_q;
	logic        busy_q;
	logic [7:0]  type_q;
	logic [7:0]  csum_hi_q;
	logic        accept;
	logic        at_end;
	logic        echo;
	logic [16:0] sum;
	logic [15:0] csum;

	// ready per mode; header collection waits until the last flush has read the store
	always_comb begin
		case (mode_q)
			MODE_COLLECT: rx.ready = !busy_q && q_ready;
			MODE_FORWARD: rx.ready = q_ready;
			MODE_DISCARD: rx.ready = 1'b1;
			default:      rx.ready = 1'b1;
		endcase
	end

	assign accept = rx.valid && rx.ready;
	assign at_end = (pos_q == POS_CSUM_LO);
	assign echo   = (type_q == TYPE_ECHO_REQUEST);

	// checksum raised by the type change, end-around carry
	assign sum  = {1'b0, csum_hi_q, rx.rx_byte} + {1'b0, CSUM_ADJ};
	assign csum = sum[15:0] + {15'd0, sum[16]};

	// queue push: a flush command at the end of an echo header, or a forwarded byte
	assign q_valid = accept && ((mode_q == MODE_FORWARD)
		|| (mode_q == MODE_COLLECT && at_end && echo));
	assign q_data.is_hdr = (mode_q == MODE_COLLECT);
	assign q_data.data   = rx.rx_byte;
	assign q_data.last   = rx.rx_last;
	assign q_data.csum   = csum;

	// header store write
	assign wr.en   = accept && (mode_q == MODE_COLLECT);
	assign wr.addr = pos_q;
	assign wr.data = rx.rx_byte;

	// mode and position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_COLLECT;
			pos_q  <= '0;
		end else if (accept) begin
			case (mode_q)
				MODE_COLLECT: begin
					if (at_end) begin
						pos_q <= '0;
						if (rx.rx_last)
							mode_q <= MODE_COLLECT;
						else if (echo)
							mode_q <= MODE_FORWARD;
						else
							mode_q <= MODE_DISCARD;
					end else if (rx.rx_last) begin
						pos_q <= '0;
					end else begin
						pos_q <= pos_q + 6'd1;
					end
				end
				default: begin
					if (rx.rx_last) begin
						mode_q <= MODE_COLLECT;
						pos_q  <= '0;
					end
				end
			endcase
		end
	end

	// store in use by a flush
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			busy_q <= 1'b0;
		else if (q_valid && q_data.is_hdr)
			busy_q <= 1'b1;
		else if (hdr_done)
			busy_q <= 1'b0;
	end

	// ICMP type and checksum high byte kept aside
	always_ff @(posedge clk) begin
		if (wr.en && pos_q == POS_ICMP_TYPE)
			type_q <= rx.rx_byte;
		if (wr.en && pos_q == POS_CSUM_HI)
			csum_hi_q <= rx.rx_byte;
	end

endmodule

/* rtl/core/icer_queue.sv */
// Short queue between the front and back ends.
`timescale 1ns / 1ps

module icer_queue
	import icer_pkg::*;
#(
	parameter int DEPTH = 4
)
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_ready,
	input  qent_t in_data,
	output logic  out_valid,
	input  logic  out_pop,
	output qent_t out_data
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	qent_t             mem_q [DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              push;
	logic              pop;

	assign in_ready  = (cnt_q != CNT_W'(DEPTH));
	assign out_valid = (cnt_q != '0);
	assign out_data  = mem_q[rd_ptr_q];
	assign push      = in_valid && in_ready;
	assign pop       = out_pop && out_valid;

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (push && !pop)
				cnt_q <= cnt_q + 1'b1;
			else if (pop && !push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

	// entry storage
	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= in_data;
	end

endmodule

/* rtl/core/icer_back.sv */
// Back end: header store, reply header flush and byte forwarding to the output.
`timescale 1ns / 1ps

module icer_back
	import icer_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  wr_t          wr,
	input  logic         q_valid,
	input  qent_t        q_data,
	output logic         q_pop,
	output logic         hdr_done,
	input  logic [47:0]  own_mac,
	input  logic [31:0]  own_ip,
	icer_tx_if.source    tx
);

	logic [7:0]  hdr_mem [HEADER_BYTES];

	logic        act_q;
	pos_t        k_q;
	logic [15:0] csum_q;
	logic        last_q;

	logic        valid_s1;
	logic        hdr_s1;
	pos_t        k_s1;
	logic [7:0]  data_s1;
	logic        dlast_s1;
	logic [7:0]  rd_s1;

	logic        tx_valid_q;
	logic [7:0]  tx_byte_q;
	logic        tx_last_q;

	logic        adv;
	logic [2:0]  mac_j;
	logic [1:0]  ip_j;
	logic [47:0] mac_sh;
	logic [31:0] ip_sh;
	logic [7:0]  obyte;
	logic        olast;

	assign adv      = !tx_valid_q || tx.ready;
	assign q_pop    = adv && !act_q && q_valid;
	assign hdr_done = adv && act_q && (k_q == POS_CSUM_LO);

	// header store: front end writes it; a flush reads one byte a cycle unless stalled
	always_ff @(posedge clk) begin
		if (wr.en)
			hdr_mem[wr.addr] <= wr.data;
		if (adv)
			rd_s1 <= hdr_mem[hdr_rd_addr(k_q)];
	end

	// flush sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q <= 1'b0;
			k_q   <= '0;
		end else if (adv) begin
			if (act_q) begin
				k_q <= k_q + 6'd1;
				if (k_q == POS_CSUM_LO)
					act_q <= 1'b0;
			end else if (q_valid && q_data.is_hdr) begin
				act_q <= 1'b1;
				k_q   <= '0;
			end
		end
	end

	// checksum and last flag of the flush under way
	always_ff @(posedge clk) begin
		if (q_pop && q_data.is_hdr) begin
			csum_q <= q_data.csum;
			last_q <= q_data.last;
		end
	end

	// read stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (adv)
			valid_s1 <= act_q || (q_valid && !q_data.is_hdr);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			hdr_s1   <= act_q;
			k_s1     <= k_q;
			data_s1  <= q_data.data;
			dlast_s1 <= q_data.last;
		end
	end

	// reply byte assembly
	assign mac_j  = 3'(k_s1 - POS_MAC_SRC);
	assign ip_j   = 2'(k_s1 - POS_IP_SRC);
	assign mac_sh = own_mac >> {3'd5 - mac_j, 3'b000};
	assign ip_sh  = own_ip >> {2'd3 - ip_j, 3'b000};

	always_comb begin
		obyte = rd_s1;
		olast = 1'b0;
		if (!hdr_s1) begin
			obyte = data_s1;
			olast = dlast_s1;
		end else begin
			olast = (k_s1 == POS_CSUM_LO) && last_q;
			if (k_s1 >= POS_MAC_SRC && k_s1 < POS_ETH_TYPE)
				obyte = mac_sh[7:0];
			else if (k_s1 >= POS_IP_SRC && k_s1 < POS_IP_DST)
				obyte = ip_sh[7:0];
			else if (k_s1 == POS_ICMP_TYPE)
				obyte = TYPE_ECHO_REPLY;
			else if (k_s1 == POS_CSUM_HI)
				obyte = csum_q[15:8];
			else if (k_s1 == POS_CSUM_LO)
				obyte = csum_q[7:0];
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			tx_valid_q <= 1'b0;
		else if (adv)
			tx_valid_q <= valid_s1;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			tx_byte_q <= obyte;
			tx_last_q <= olast;
		end
	end

	assign tx.valid   = tx_valid_q;
	assign tx.tx_byte = tx_byte_q;
	assign tx.tx_last = tx_last_q;

`ifndef SYNTH
	// the front end never rewrites the store while a flush reads it
	a_no_write_in_flush: assert property (@(posedge clk) disable iff (!arst_n)
		wr.en |-> !act_q)
		else $error("header store written during flush");

	// queue is held while a flush runs
	a_no_pop_in_flush: assert property (@(posedge clk) disable iff (!arst_n)
		act_q |-> !q_pop)
		else $error("queue popped during flush");

	// a finished flush leaves the sequencer idle with its counter past the header
	a_flush_end: assert property (@(posedge clk) disable iff (!arst_n)
		hdr_done |=> !act_q && k_q == 6'(HEADER_BYTES))
		else $error("flush did not end cleanly");
`endif

endmodule

/* rtl/core/icer_echo_reply_rewriter_top_note.sv */
// Configuration registers: APB-style write and read of the own MAC and own IP addresses.
`timescale 1ns / 1ps

module icer_cfg
	import icer_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [3:0]   paddr,
	input  logic [63:0]  pwdata,
	output logic [63:0]  prdata,
	output logic [47:0]  own_mac,
	output logic [31:0]  own_ip
);

	logic [47:0] own_mac_q;
	logic [31:0] own_ip_q;
	logic        wr_en;

	assign wr_en = psel && penable && pwrite;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_mac_q <= '0;
			own_ip_q  <= '0;
		end else if (wr_en) begin
			case (paddr[3])
				REG_OWN_MAC: own_mac_q <= pwdata[47:0];
				REG_OWN_IP:  own_ip_q  <= pwdata[31:0];
				default:     own_ip_q  <= own_ip_q;
			endcase
		end
	end

	// read mux
	always_comb begin
		case (paddr[3])
			REG_OWN_MAC: prdata = {16'd0, own_mac_q};
			REG_OWN_IP:  prdata = {32'd0, own_ip_q};
			default:     prdata = '0;
		endcase
	end

	assign own_mac = own_mac_q;
	assign own_ip  = own_ip_q;

endmodule

/* rtl/core/icmp_echo_reply_rewriter.sv */
// Top level of the ICMP echo reply rewriter.
//
//   channel  dir  fields              transfer when
//   rx       in   rx_byte, rx_last    rx.valid && rx.ready
//   tx       out  tx_byte, tx_last    tx.valid && tx.ready
//   apb      in   own_mac, own_ip     psel && penable && pwrite (pready tied high)
//
// A forwarded byte passes the front end unregistered, then the queue, read stage and
// output register. An echo request header leaves as 38 bytes, one a cycle unless the
// output stalls, from the header store read port; the next frame's header collection
// waits until that read is done. The queue holds QUEUE_DEPTH entries during stalls.
// Reset clears modes, counters, flags and config; store and data registers are kept.
`timescale 1ns / 1ps

module icmp_echo_reply_rewriter
	import icer_pkg::*;
#(
	parameter int QUEUE_DEPTH = 4
)
(
	input  logic         clk,
	input  logic         arst_n,
	icer_rx_if.sink      rx,
	icer_tx_if.source    tx,
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [3:0]   paddr,
	input  logic [63:0]  pwdata,
	output logic [63:0]  prdata,
	output logic         pready
);

	logic [47:0] own_mac;
	logic [31:0] own_ip;
	logic        fq_valid;
	logic        fq_ready;
	qent_t       fq_data;
	logic        bq_valid;
	logic        bq_pop;
	qent_t       bq_data;
	logic        hdr_done;
	wr_t         wr;

	assign pready = 1'b1;

	icer_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.own_mac (own_mac),
		.own_ip  (own_ip)
	);

	icer_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.rx       (rx),
		.q_valid  (fq_valid),
		.q_ready  (fq_ready),
		.q_data   (fq_data),
		.hdr_done (hdr_done),
		.wr       (wr)
	);

	icer_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (fq_valid),
		.in_ready  (fq_ready),
		.in_data   (fq_data),
		.out_valid (bq_valid),
		.out_pop   (bq_pop),
		.out_data  (bq_data)
	);

	icer_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr       (wr),
		.q_valid  (bq_valid),
		.q_data   (bq_data),
		.q_pop    (bq_pop),
		.hdr_done (hdr_done),
		.own_mac  (own_mac),
		.own_ip   (own_ip),
		.tx       (tx)
	);

endmodule
